/* rtl/http_request_head_parser_assert.svh */
// Assertion macros used by the request head parser top level.
`ifndef HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HRP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("request head parser check failed");

// Next-cycle implication, checked outside reset.
`define HRP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("request head parser check failed");

`endif

/* rtl/hrp_pkg.sv */
// Types, codes and character constants of the request head parser.
package hrp_pkg;

   localparam int STATE_BITS = 5;

   localparam logic [STATE_BITS-1:0] ST_METHOD_START       = 5'd0;
   localparam logic [STATE_BITS-1:0] ST_METHOD             = 5'd1;
   localparam logic [STATE_BITS-1:0] ST_URI                = 5'd2;
   localparam logic [STATE_BITS-1:0] ST_VER_H              = 5'd3;
   localparam logic [STATE_BITS-1:0] ST_VER_T1             = 5'd4;
   localparam logic [STATE_BITS-1:0] ST_VER_T2             = 5'd5;
   localparam logic [STATE_BITS-1:0] ST_VER_P              = 5'd6;
   localparam logic [STATE_BITS-1:0] ST_VER_SLASH          = 5'd7;
   localparam logic [STATE_BITS-1:0] ST_MAJOR_START        = 5'd8;
   localparam logic [STATE_BITS-1:0] ST_MAJOR              = 5'd9;
   localparam logic [STATE_BITS-1:0] ST_MINOR_START        = 5'd10;
   localparam logic [STATE_BITS-1:0] ST_MINOR              = 5'd11;
   localparam logic [STATE_BITS-1:0] ST_LF1                = 5'd12;
   localparam logic [STATE_BITS-1:0] ST_LINE_START         = 5'd13;
   localparam logic [STATE_BITS-1:0] ST_LWS                = 5'd14;
   localparam logic [STATE_BITS-1:0] ST_NAME               = 5'd15;
   localparam logic [STATE_BITS-1:0] ST_SPACE_BEFORE_VALUE = 5'd16;
   localparam logic [STATE_BITS-1:0] ST_VALUE              = 5'd17;
   localparam logic [STATE_BITS-1:0] ST_LF2                = 5'd18;
   localparam logic [STATE_BITS-1:0] ST_LF3                = 5'd19;

   localparam logic [1:0] STATUS_PENDING = 2'd0;
   localparam logic [1:0] STATUS_DONE    = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;

   localparam logic [2:0] CLASS_NONE   = 3'd0;
   localparam logic [2:0] CLASS_METHOD = 3'd1;
   localparam logic [2:0] CLASS_URI    = 3'd2;
   localparam logic [2:0] CLASS_NAME   = 3'd3;
   localparam logic [2:0] CLASS_VALUE  = 3'd4;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   typedef struct packed {
      logic [STATE_BITS-1:0] state;
      logic                  seen_header;
   } ctrl_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] byte_class;
      logic       header_begin;
   } result_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic logic is_cntrl(input logic [7:0] c);
      return c < CH_SP || c == CH_DEL;
   endfunction

endpackage

/* rtl/http_request_head_parser.sv */
// Top level of the HTTP/1.1 request head parser.
// Usage: the request head is fed one byte per item on the req_ channel
// (req_valid, req_stall, req_data_byte). For every byte one result item leaves
// on the rsp_ channel with the status (pending, complete, malformed), the class
// of the byte (method, URI, header name, header value or delimiter), a flag for
// the first byte of a header name, the echoed byte and the version numbers so far.
// A byte is held in an input register, checked against the grammar by the
// step logic and written into the result register. One byte is accepted in
// every cycle while the receiver takes results; the parse state register
// updates once per byte. When rsp_stall is high the result register holds and
// one more byte may wait in the input register; after that req_stall rises
// until the result moves. A malformed byte leaves the parse state untouched.
// After the final LF the parser keeps its final state until reset; another LF
// reads complete, any other byte malformed. Synchronous reset empties both
// registers and returns the parser to the start of the method, versions at zero.
module http_request_head_parser #(
   parameter int VERSION_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_byte_class,
   output logic       rsp_header_begin,
   output logic [7:0] rsp_byte_out,
   output logic [7:0] rsp_version_major,
   output logic [7:0] rsp_version_minor
);

`include "http_request_head_parser_assert.svh"

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff, in_byte_in;
   hrp_pkg::ctrl_type       ctrl_ff, ctrl_in;
   logic [VERSION_BITS-1:0] major_ff, major_in;
   logic [VERSION_BITS-1:0] minor_ff, minor_in;
   logic                    out_valid_ff, out_valid_in;
   hrp_pkg::result_type     out_res_ff, out_res_in;
   logic [7:0]              out_byte_ff, out_byte_in;
   logic [7:0]              out_major_ff, out_major_in;
   logic [7:0]              out_minor_ff, out_minor_in;

   hrp_pkg::ctrl_type       ctrl_step;
   logic [VERSION_BITS-1:0] major_step;
   logic [VERSION_BITS-1:0] minor_step;
   hrp_pkg::result_type     res_step;
   logic [VERSION_BITS+7:0] major_ext;
   logic [VERSION_BITS+7:0] minor_ext;
   logic                    out_free;
   logic                    advance;
   logic                    req_take;

   hrp_step #(
      .VERSION_BITS(VERSION_BITS)
   ) u_step (
      .data_byte (in_byte_ff),
      .ctrl_cur  (ctrl_ff),
      .major_cur (major_ff),
      .minor_cur (minor_ff),
      .ctrl_nxt  (ctrl_step),
      .major_nxt (major_step),
      .minor_nxt (minor_step),
      .result    (res_step)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign major_ext = {8'd0, major_step};
   assign minor_ext = {8'd0, minor_step};

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      ctrl_in      = ctrl_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      out_byte_in  = out_byte_ff;
      out_major_in = out_major_ff;
      out_minor_in = out_minor_ff;
      if (advance || !in_valid_ff) begin
         in_valid_in = req_take;
         in_byte_in  = req_data_byte;
      end
      if (advance) begin
         ctrl_in      = ctrl_step;
         major_in     = major_step;
         minor_in     = minor_step;
         out_res_in   = res_step;
         out_byte_in  = in_byte_ff;
         out_major_in = major_ext[7:0];
         out_minor_in = minor_ext[7:0];
      end
      if (out_free) begin
         out_valid_in = advance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctrl_ff      <= '{state: hrp_pkg::ST_METHOD_START, seen_header: 1'b0};
         major_ff     <= '0;
         minor_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctrl_ff      <= ctrl_in;
         major_ff     <= major_in;
         minor_ff     <= minor_in;
      end
      in_byte_ff   <= in_byte_in;
      out_res_ff   <= out_res_in;
      out_byte_ff  <= out_byte_in;
      out_major_ff <= out_major_in;
      out_minor_ff <= out_minor_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_res_ff.status;
   assign rsp_byte_class    = out_res_ff.byte_class;
   assign rsp_header_begin  = out_res_ff.header_begin;
   assign rsp_byte_out      = out_byte_ff;
   assign rsp_version_major = out_major_ff;
   assign rsp_version_minor = out_minor_ff;

   `HRP_ASSERT_NEXT(a_bad_keeps_state, clock, reset,
      advance && res_step.status == hrp_pkg::STATUS_BAD, ctrl_ff == $past(ctrl_ff))
   `HRP_ASSERT_NEXT(a_done_stays_final, clock, reset,
      advance && res_step.status == hrp_pkg::STATUS_DONE, ctrl_ff.state == hrp_pkg::ST_LF3)
   `HRP_ASSERT_NOW(a_bad_has_no_class, clock, reset,
      out_valid_ff && out_res_ff.status == hrp_pkg::STATUS_BAD,
      out_res_ff.byte_class == hrp_pkg::CLASS_NONE && !out_res_ff.header_begin)
   `HRP_ASSERT_NOW(a_begin_is_name, clock, reset,
      out_valid_ff && out_res_ff.header_begin,
      out_res_ff.byte_class == hrp_pkg::CLASS_NAME && ctrl_ff.seen_header)

endmodule

/* rtl/hrp_step.sv */
// Combinational grammar step: next parse state, version values and result of one byte.
module hrp_step #(
   parameter int VERSION_BITS = 8
) (
   input  logic [7:0]              data_byte,
   input  hrp_pkg::ctrl_type       ctrl_cur,
   input  logic [VERSION_BITS-1:0] major_cur,
   input  logic [VERSION_BITS-1:0] minor_cur,
   output hrp_pkg::ctrl_type       ctrl_nxt,
   output logic [VERSION_BITS-1:0] major_nxt,
   output logic [VERSION_BITS-1:0] minor_nxt,
   output hrp_pkg::result_type     result
);

   localparam int SUM_BITS = VERSION_BITS + 4;
   localparam logic [SUM_BITS-1:0] VERSION_MAX = {4'd0, {VERSION_BITS{1'b1}}};

   function automatic logic [VERSION_BITS-1:0] add_digit(
      input logic [VERSION_BITS-1:0] v,
      input logic [7:0]              c
   );
      logic [SUM_BITS-1:0] wide;
      logic [7:0]          d8;
      logic [SUM_BITS-1:0] sum;
      wide = {4'd0, v};
      d8   = c - hrp_pkg::CH_0;
      sum  = (wide << 3) + (wide << 1) + {{(SUM_BITS-4){1'b0}}, d8[3:0]};
      if (sum > VERSION_MAX) begin
         return {VERSION_BITS{1'b1}};
      end
      return sum[VERSION_BITS-1:0];
   endfunction

   logic                    bad;
   hrp_pkg::ctrl_type       ctrl_try;
   logic [VERSION_BITS-1:0] major_try;
   logic [VERSION_BITS-1:0] minor_try;
   hrp_pkg::result_type     res_try;

   always_comb begin
      ctrl_try  = ctrl_cur;
      major_try = major_cur;
      minor_try = minor_cur;
      res_try   = '{status: hrp_pkg::STATUS_PENDING, byte_class: hrp_pkg::CLASS_NONE,
                    header_begin: 1'b0};
      bad       = 1'b0;
      case (ctrl_cur.state)
         hrp_pkg::ST_METHOD_START: begin
            if (hrp_pkg::is_alpha(data_byte)) begin
               res_try.byte_class = hrp_pkg::CLASS_METHOD;
               ctrl_try.state     = hrp_pkg::ST_METHOD;
            end else begin
               bad = 1'b1;
            end
         end
         hrp_pkg::ST_METHOD: begin
            if (data_byte == hrp_pkg::CH_SP) begin
               ctrl_try.state = hrp_pkg::ST_URI;
            end else if (hrp_pkg::is_alpha(data_byte)) begin
               res_try.byte_class = hrp_pkg::CLASS_METHOD;
            end else begin
               bad = 1'b1;
            end
         end
         hrp_pkg::ST_URI: begin
            if (data_byte == hrp_pkg::CH_SP) begin
               ctrl_try.state = hrp_pkg::ST_VER_H;
            end else if (hrp_pkg::is_cntrl(data_byte)) begin
               bad = 1'b1;
            end else begin
               res_try.byte_class = hrp_pkg::CLASS_URI;
            end
         end
         hrp_pkg::ST_VER_H: begin
            if (data_byte == hrp_pkg::CH_H) ctrl_try.state = hrp_pkg::ST_VER_T1;
            else bad = 1'b1;
         end
         hrp_pkg::ST_VER_T1: begin
            if (data_byte == hrp_pkg::CH_T) ctrl_try.state = hrp_pkg::ST_VER_T2;
            else bad = 1'b1;
         end
         hrp_pkg::ST_VER_T2: begin
            if (data_byte == hrp_pkg::CH_T) ctrl_try.state = hrp_pkg::ST_VER_P;
            else bad = 1'b1;
         end
         hrp_pkg::ST_VER_P: begin
            if (data_byte == hrp_pkg::CH_P) ctrl_try.state = hrp_pkg::ST_VER_SLASH;
            else bad = 1'b1;
         end
         hrp_pkg::ST_VER_SLASH: begin
            if (data_byte == hrp_pkg::CH_SLASH) ctrl_try.state = hrp_pkg::ST_MAJOR_START;
            else bad = 1'b1;
         end
         hrp_pkg::ST_MAJOR_START: begin
            if (hrp_pkg::is_digit(data_byte)) begin
               major_try      = add_digit('0, data_byte);
               ctrl_try.state = hrp_pkg::ST_MAJOR;
            end else begin
               bad = 1'b1;
            end
         end
         hrp_pkg::ST_MAJOR: begin
            if (data_byte == hrp_pkg::CH_DOT) begin
               ctrl_try.state = hrp_pkg::ST_MINOR_START;
            end else if (hrp_pkg::is_digit(data_byte)) begin
               major_try = add_digit(major_cur, data_byte);
            end else begin
               bad = 1'b1;
            end
         end
         hrp_pkg::ST_MINOR_START: begin
            if (hrp_pkg::is_digit(data_byte)) begin
               minor_try      = add_digit('0, data_byte);
               ctrl_try.state = hrp_pkg::ST_MINOR;
            end else begin
               bad = 1'b1;
            end
         end
         hrp_pkg::ST_MINOR: begin
            if (data_byte == hrp_pkg::CH_CR) begin
               ctrl_try.state = hrp_pkg::ST_LF1;
            end else if (hrp_pkg::is_digit(data_byte)) begin
               minor_try = add_digit(minor_cur, data_byte);
            end else begin
               bad = 1'b1;
            end
         end
         hrp_pkg::ST_LF1: begin
            if (data_byte == hrp_pkg::CH_LF) ctrl_try.state = hrp_pkg::ST_LINE_START;
            else bad = 1'b1;
         end
         hrp_pkg::ST_LINE_START: begin
            if (data_byte == hrp_pkg::CH_CR) begin
               ctrl_try.state = hrp_pkg::ST_LF3;
            end else if (ctrl_cur.seen_header &&
                         (data_byte == hrp_pkg::CH_SP || data_byte == hrp_pkg::CH_TAB)) begin
               ctrl_try.state = hrp_pkg::ST_LWS;
            end else if (!hrp_pkg::is_cntrl(data_byte) && data_byte != hrp_pkg::CH_COLON &&
                         data_byte != hrp_pkg::CH_SP) begin
               ctrl_try.seen_header = 1'b1;
               ctrl_try.state       = hrp_pkg::ST_NAME;
               res_try.byte_class   = hrp_pkg::CLASS_NAME;
               res_try.header_begin = 1'b1;
            end else begin
               bad = 1'b1;
            end
         end
         hrp_pkg::ST_LWS: begin
            if (data_byte == hrp_pkg::CH_CR) begin
               ctrl_try.state = hrp_pkg::ST_LF2;
            end else if (data_byte == hrp_pkg::CH_SP || data_byte == hrp_pkg::CH_TAB) begin
               ctrl_try.state = hrp_pkg::ST_LWS;
            end else if (!hrp_pkg::is_cntrl(data_byte)) begin
               res_try.byte_class = hrp_pkg::CLASS_VALUE;
               ctrl_try.state     = hrp_pkg::ST_VALUE;
            end else begin
               bad = 1'b1;
            end
         end
         hrp_pkg::ST_NAME: begin
            if (data_byte == hrp_pkg::CH_COLON) begin
               ctrl_try.state = hrp_pkg::ST_SPACE_BEFORE_VALUE;
            end else if (!hrp_pkg::is_cntrl(data_byte) && data_byte != hrp_pkg::CH_SP) begin
               res_try.byte_class = hrp_pkg::CLASS_NAME;
            end else begin
               bad = 1'b1;
            end
         end
         hrp_pkg::ST_SPACE_BEFORE_VALUE: begin
            if (data_byte == hrp_pkg::CH_SP) ctrl_try.state = hrp_pkg::ST_VALUE;
            else bad = 1'b1;
         end
         hrp_pkg::ST_VALUE: begin
            if (data_byte == hrp_pkg::CH_CR) begin
               ctrl_try.state = hrp_pkg::ST_LF2;
            end else if (hrp_pkg::is_cntrl(data_byte)) begin
               bad = 1'b1;
            end else begin
               res_try.byte_class = hrp_pkg::CLASS_VALUE;
            end
         end
         hrp_pkg::ST_LF2: begin
            if (data_byte == hrp_pkg::CH_LF) ctrl_try.state = hrp_pkg::ST_LINE_START;
            else bad = 1'b1;
         end
         hrp_pkg::ST_LF3: begin
            if (data_byte == hrp_pkg::CH_LF) res_try.status = hrp_pkg::STATUS_DONE;
            else bad = 1'b1;
         end
         default: begin
            bad = 1'b1;
         end
      endcase
   end

   // A malformed byte leaves all parse state as it was.
   always_comb begin
      if (bad) begin
         ctrl_nxt  = ctrl_cur;
         major_nxt = major_cur;
         minor_nxt = minor_cur;
         result    = '{status: hrp_pkg::STATUS_BAD, byte_class: hrp_pkg::CLASS_NONE,
                       header_begin: 1'b0};
      end else begin
         ctrl_nxt  = ctrl_try;
         major_nxt = major_try;
         minor_nxt = minor_try;
         result    = res_try;
      end
   end

endmodule
